// ===== rtl/core/isc_pkg.sv =====
// Shared types and constants for the image scaler core.
// No dependencies; used by every module of the scaler.
package isc_pkg;

    // default source store dimensions
    localparam int DEF_MAX_WIDTH  = 512;
    localparam int DEF_MAX_HEIGHT = 512;

    // field widths
    localparam int COORD_W   = 16;
    localparam int PIX_W     = 8;
    localparam int DIM_W     = 10;
    localparam int SCALE_W   = 24;
    localparam int FRAC_W    = 16;
    localparam int PROD_W    = COORD_W + SCALE_W;
    localparam int CFG_IDX_W = 2;

    // source column/row carried between front and back, covers the largest store
    localparam int IDX_W = 12;

    // compare width for integer source coordinates against the image size
    localparam int CMP_W = SCALE_W + 1;

    // entries in the work queue, power of two
    localparam int QUEUE_DEPTH = 2;

    localparam logic [SCALE_W-1:0] SCALE_ONE   = 24'h010000;
    localparam logic [PIX_W-1:0]   WHITE_PIXEL = 8'hFF;

    // what the back end has to do with one queued item
    typedef enum logic [1:0] {
        KIND_LOAD   = 2'd0,
        KIND_WHITE  = 2'd1,
        KIND_SINGLE = 2'd2,
        KIND_BILIN  = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [COORD_W-1:0] out_x;
        logic [COORD_W-1:0] out_y;
        logic [IDX_W-1:0]   col;
        logic [IDX_W-1:0]   row;
        logic [FRAC_W-1:0]  fx;
        logic [FRAC_W-1:0]  fy;
        logic [PIX_W-1:0]   pixel;
    } work_t;

endpackage

// ===== rtl/core/isc_front.sv =====
// Front end of the image scaler: takes input transfers, maps coordinates, classifies.
// Depends on isc_pkg; feeds isc_queue.
module isc_front #(
    parameter int MAX_WIDTH  = isc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = isc_pkg::DEF_MAX_HEIGHT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_mode,
    input  logic [isc_pkg::COORD_W-1:0]  s_coord_x,
    input  logic [isc_pkg::COORD_W-1:0]  s_coord_y,
    input  logic [isc_pkg::PIX_W-1:0]    s_pixel_in,
    input  logic [isc_pkg::DIM_W-1:0]    source_width,
    input  logic [isc_pkg::DIM_W-1:0]    source_height,
    input  logic [isc_pkg::SCALE_W-1:0]  inverse_scale,
    input  logic                         interp_mode,
    output logic                         q_valid,
    input  logic                         q_ready,
    output isc_pkg::work_t               q_entry
);

    localparam logic MODE_LOAD       = 1'b0;
    localparam logic INTERP_BILINEAR = 1'b1;
    localparam int   CMP_W  = isc_pkg::CMP_W;
    localparam int   PROD_W = isc_pkg::PROD_W;
    localparam int   FRAC_W = isc_pkg::FRAC_W;
    localparam int   IDX_W  = isc_pkg::IDX_W;

    logic                         a_valid_reg;
    logic                         a_mode_reg;
    logic [isc_pkg::COORD_W-1:0]  a_x_reg;
    logic [isc_pkg::COORD_W-1:0]  a_y_reg;
    logic [isc_pkg::PIX_W-1:0]    a_pix_reg;
    logic [PROD_W-1:0]            a_sx_reg;
    logic [PROD_W-1:0]            a_sy_reg;

    logic             s_take;
    logic             a_keep;
    logic             a_done;
    logic             load_ok;
    logic             zero_dim;
    logic             use_bilin;
    logic             at_edge;
    logic [CMP_W-1:0] w_use;
    logic [CMP_W-1:0] h_use;
    logic [CMP_W-1:0] x_fl;
    logic [CMP_W-1:0] y_fl;
    logic [CMP_W-1:0] x_rn;
    logic [CMP_W-1:0] y_rn;
    logic [CMP_W-1:0] x_sat;
    logic [CMP_W-1:0] y_sat;

    // handshake
    assign s_take  = s_valid && s_ready;
    assign a_keep  = (a_mode_reg != MODE_LOAD) || load_ok;
    assign q_valid = a_valid_reg && a_keep;
    assign a_done  = a_valid_reg && (!a_keep || q_ready);
    assign s_ready = !a_valid_reg || a_done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (s_take) begin
            a_valid_reg <= 1'b1;
        end else if (a_done) begin
            a_valid_reg <= 1'b0;
        end
    end

    // capture item and scale both coordinates into Q.16 source positions
    always_ff @(posedge aclk) begin
        if (s_take) begin
            a_mode_reg <= s_mode;
            a_x_reg    <= s_coord_x;
            a_y_reg    <= s_coord_y;
            a_pix_reg  <= s_pixel_in;
            a_sx_reg   <= PROD_W'(s_coord_x) * PROD_W'(inverse_scale);
            a_sy_reg   <= PROD_W'(s_coord_y) * PROD_W'(inverse_scale);
        end
    end

    // usable image size and source positions
    always_comb begin
        w_use = (int'(source_width) < MAX_WIDTH) ? CMP_W'(source_width) : CMP_W'(MAX_WIDTH);
        h_use = (int'(source_height) < MAX_HEIGHT) ? CMP_W'(source_height)
                                                  : CMP_W'(MAX_HEIGHT);
        x_fl  = CMP_W'(a_sx_reg[PROD_W-1:FRAC_W]);
        y_fl  = CMP_W'(a_sy_reg[PROD_W-1:FRAC_W]);
        x_rn  = x_fl + CMP_W'(a_sx_reg[FRAC_W-1]);
        y_rn  = y_fl + CMP_W'(a_sy_reg[FRAC_W-1]);
        x_sat = (x_fl > w_use - CMP_W'(1)) ? w_use - CMP_W'(1) : x_fl;
        y_sat = (y_fl > h_use - CMP_W'(1)) ? h_use - CMP_W'(1) : y_fl;
        zero_dim  = (w_use == '0) || (h_use == '0);
        use_bilin = (interp_mode == INTERP_BILINEAR) && (inverse_scale < isc_pkg::SCALE_ONE);
        at_edge   = (x_fl + CMP_W'(1) >= w_use) || (y_fl + CMP_W'(1) >= h_use);
        load_ok   = (int'(a_x_reg) < MAX_WIDTH) && (int'(a_y_reg) < MAX_HEIGHT);
    end

    // classify the item for the back end
    always_comb begin
        q_entry.kind  = isc_pkg::KIND_LOAD;
        q_entry.out_x = a_x_reg;
        q_entry.out_y = a_y_reg;
        q_entry.col   = a_x_reg[IDX_W-1:0];
        q_entry.row   = a_y_reg[IDX_W-1:0];
        q_entry.fx    = a_sx_reg[FRAC_W-1:0];
        q_entry.fy    = a_sy_reg[FRAC_W-1:0];
        q_entry.pixel = a_pix_reg;
        if (a_mode_reg == MODE_LOAD) begin
            q_entry.kind = isc_pkg::KIND_LOAD;
        end else if (zero_dim) begin
            q_entry.kind = isc_pkg::KIND_WHITE;
        end else if (use_bilin) begin
            if (at_edge) begin
                // edge: top-left neighbour, clamped into the image
                q_entry.kind = isc_pkg::KIND_SINGLE;
                q_entry.col  = x_sat[IDX_W-1:0];
                q_entry.row  = y_sat[IDX_W-1:0];
            end else begin
                q_entry.kind = isc_pkg::KIND_BILIN;
                q_entry.col  = x_fl[IDX_W-1:0];
                q_entry.row  = y_fl[IDX_W-1:0];
            end
        end else if ((x_rn >= w_use) || (y_rn >= h_use)) begin
            q_entry.kind = isc_pkg::KIND_WHITE;
        end else begin
            q_entry.kind = isc_pkg::KIND_SINGLE;
            q_entry.col  = x_rn[IDX_W-1:0];
            q_entry.row  = y_rn[IDX_W-1:0];
        end
    end

endmodule

// ===== rtl/core/isc_queue.sv =====
// Small work queue between the scaler front end and back end.
// Depends on isc_pkg for the entry type and depth.
module isc_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_valid,
    output logic           push_ready,
    input  isc_pkg::work_t push_data,
    output logic           pop_valid,
    input  logic           pop_ready,
    output isc_pkg::work_t pop_data
);

    localparam int DEPTH = isc_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    isc_pkg::work_t   entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = entry_reg[rd_ptr_reg];

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/core/isc_back.sv =====
// Back end of the image scaler: source pixel store, neighbour reads, interpolation.
// Depends on isc_pkg; drives the result channel through an output register.
module isc_back #(
    parameter int MAX_WIDTH  = isc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = isc_pkg::DEF_MAX_HEIGHT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         q_valid,
    output logic                         q_ready,
    input  isc_pkg::work_t               q_entry,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [isc_pkg::COORD_W-1:0]  m_out_x,
    output logic [isc_pkg::COORD_W-1:0]  m_out_y,
    output logic [isc_pkg::PIX_W-1:0]    m_pixel_out,
    output logic                         m_outside
);

    localparam int XW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW        = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int ADDR_W    = XW + YW;
    localparam int MEM_DEPTH = 1 << ADDR_W;
    localparam int PIX_W     = isc_pkg::PIX_W;
    localparam int FRAC_W    = isc_pkg::FRAC_W;
    localparam int T_W       = PIX_W + FRAC_W;
    localparam int VP_W      = T_W + FRAC_W + 2;
    localparam int STEP_W    = 3;

    // bilinear sequence steps
    localparam logic [STEP_W-1:0] STEP_P00  = 3'd1;
    localparam logic [STEP_W-1:0] STEP_T1   = 3'd2;
    localparam logic [STEP_W-1:0] STEP_P01  = 3'd3;
    localparam logic [STEP_W-1:0] STEP_T2   = 3'd4;
    localparam logic [STEP_W-1:0] STEP_VMUL = 3'd5;
    localparam logic [STEP_W-1:0] STEP_SUM  = 3'd6;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    // horizontal blend: pa*(1-f) + pb*f, exact in Q.16
    function automatic logic [T_W-1:0] hlerp(input logic [PIX_W-1:0] pa,
                                             input logic [PIX_W-1:0] pb,
                                             input logic [FRAC_W-1:0] frac);
        logic signed [PIX_W:0]    diff;
        logic signed [T_W+1:0]    prod;
        logic signed [T_W+1:0]    sum;
        diff = $signed({1'b0, pb}) - $signed({1'b0, pa});
        prod = (T_W+2)'(diff) * (T_W+2)'($signed({1'b0, frac}));
        sum  = $signed({2'b00, pa, {FRAC_W{1'b0}}}) + prod;
        return sum[T_W-1:0];
    endfunction

    logic [PIX_W-1:0] pixel_mem [MEM_DEPTH];

    state_t                    state_reg, state_next;
    logic [STEP_W-1:0]         step_reg, step_next;
    isc_pkg::work_t            cur_reg;
    logic [PIX_W-1:0]          rd_data_reg;
    logic [PIX_W-1:0]          p_reg, p_next;
    logic [T_W-1:0]            t1_reg, t1_next;
    logic [T_W-1:0]            t2_reg, t2_next;
    logic signed [VP_W-1:0]    vprod_reg, vprod_next;
    logic [PIX_W-1:0]          res_pix_reg, res_pix_next;
    logic                      res_outside_reg, res_outside_next;
    logic                      m_valid_reg;
    logic [isc_pkg::COORD_W-1:0] m_x_reg;
    logic [isc_pkg::COORD_W-1:0] m_y_reg;
    logic [PIX_W-1:0]          m_pix_reg;
    logic                      m_out_reg;

    logic                      mem_we;
    logic [ADDR_W-1:0]         mem_addr;
    logic [XW-1:0]             col_sel;
    logic [YW-1:0]             row_sel;
    logic                      is_bilin;
    logic                      load_out;
    logic signed [T_W:0]       vdiff;
    logic signed [VP_W-1:0]    vsum;

    assign q_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_out_x     = m_x_reg;
    assign m_out_y     = m_y_reg;
    assign m_pixel_out = m_pix_reg;
    assign m_outside   = m_out_reg;

    // neighbour address: step bit 0 moves right, bit 1 moves down
    assign is_bilin = (cur_reg.kind == isc_pkg::KIND_BILIN);
    assign col_sel  = cur_reg.col[XW-1:0] + XW'(is_bilin && step_reg[0]);
    assign row_sel  = cur_reg.row[YW-1:0] + YW'(is_bilin && step_reg[1]);
    assign mem_addr = {row_sel, col_sel};

    // vertical blend terms
    assign vdiff = $signed({1'b0, t2_reg}) - $signed({1'b0, t1_reg});
    assign vsum  = $signed({2'b00, t1_reg, {FRAC_W{1'b0}}}) + vprod_reg;

    // single-port pixel store, registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            pixel_mem[mem_addr] <= cur_reg.pixel;
        end
        rd_data_reg <= pixel_mem[mem_addr];
    end

    // sequencer
    always_comb begin
        state_next       = state_reg;
        step_next        = step_reg;
        mem_we           = 1'b0;
        load_out         = 1'b0;
        p_next           = p_reg;
        t1_next          = t1_reg;
        t2_next          = t2_reg;
        vprod_next       = vprod_reg;
        res_pix_next     = res_pix_reg;
        res_outside_next = res_outside_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    state_next = ST_RUN;
                    step_next  = '0;
                end
            end
            ST_RUN: begin
                step_next = step_reg + STEP_W'(1);
                unique case (cur_reg.kind)
                    isc_pkg::KIND_LOAD: begin
                        mem_we     = 1'b1;
                        state_next = ST_IDLE;
                    end
                    isc_pkg::KIND_WHITE: begin
                        res_pix_next     = isc_pkg::WHITE_PIXEL;
                        res_outside_next = 1'b1;
                        state_next       = ST_DONE;
                    end
                    isc_pkg::KIND_SINGLE: begin
                        if (step_reg == STEP_P00) begin
                            res_pix_next     = rd_data_reg;
                            res_outside_next = 1'b0;
                            state_next       = ST_DONE;
                        end
                    end
                    isc_pkg::KIND_BILIN: begin
                        res_outside_next = 1'b0;
                        case (step_reg)
                            STEP_P00:  p_next = rd_data_reg;
                            STEP_T1:   t1_next = hlerp(p_reg, rd_data_reg, cur_reg.fx);
                            STEP_P01:  p_next = rd_data_reg;
                            STEP_T2:   t2_next = hlerp(p_reg, rd_data_reg, cur_reg.fx);
                            STEP_VMUL: vprod_next = VP_W'(vdiff) * VP_W'($signed({1'b0, cur_reg.fy}));
                            STEP_SUM: begin
                                res_pix_next = vsum[T_W+FRAC_W-1:2*FRAC_W];
                                state_next   = ST_DONE;
                            end
                            default: ;
                        endcase
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        step_reg        <= step_next;
        p_reg           <= p_next;
        t1_reg          <= t1_next;
        t2_reg          <= t2_next;
        vprod_reg       <= vprod_next;
        res_pix_reg     <= res_pix_next;
        res_outside_reg <= res_outside_next;
        if (q_valid && q_ready) begin
            cur_reg <= q_entry;
        end
        if (load_out) begin
            m_x_reg   <= cur_reg.out_x;
            m_y_reg   <= cur_reg.out_y;
            m_pix_reg <= res_pix_reg;
            m_out_reg <= res_outside_reg;
        end
    end

endmodule

// ===== rtl/core/image_scaler_nearest_bilinear.sv =====
// Grayscale image scaler, top level: configuration registers and the
// front end / queue / back end chain. Depends on isc_pkg, isc_front,
// isc_queue and isc_back.
//
// Usage: the s_ channel carries load items (s_mode 0: store s_pixel_in at
// s_coord_x, s_coord_y) and request items (s_mode 1: one scaled pixel for
// the output coordinate). Each request gives one transfer on the m_ channel;
// loads give none. The cfg channel writes source_width (0), source_height (1),
// inverse_scale (2, Q8.16) and interp_mode (3); cfg_ready is always high,
// but the user must make writes only while the block is idle; the block
// itself does not enforce this. The back end's single-port pixel store
// and sequencer take one item at a time and accept no new item before the
// last is through; a bilinear pixel needs four reads plus the blend steps.
// The front end and a two-entry queue keep taking items while the back end
// works or the receiver stalls; a stalled result waits in the output
// register and backs up the queue, then s_ready. Reset empties the queue
// and output register and restores the register defaults; the pixel store
// is not cleared and holds unknown data until loaded.
module image_scaler_nearest_bilinear #(
    parameter int MAX_WIDTH  = isc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = isc_pkg::DEF_MAX_HEIGHT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [isc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [isc_pkg::SCALE_W-1:0]   cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_mode,
    input  logic [isc_pkg::COORD_W-1:0]   s_coord_x,
    input  logic [isc_pkg::COORD_W-1:0]   s_coord_y,
    input  logic [isc_pkg::PIX_W-1:0]     s_pixel_in,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [isc_pkg::COORD_W-1:0]   m_out_x,
    output logic [isc_pkg::COORD_W-1:0]   m_out_y,
    output logic [isc_pkg::PIX_W-1:0]     m_pixel_out,
    output logic                          m_outside
);

    localparam int DIM_W = isc_pkg::DIM_W;

    // register map
    localparam logic [isc_pkg::CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [isc_pkg::CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [isc_pkg::CFG_IDX_W-1:0] REG_SCALE  = 2'd2;
    localparam logic [isc_pkg::CFG_IDX_W-1:0] REG_MODE   = 2'd3;

    logic [DIM_W-1:0]            source_width_reg;
    logic [DIM_W-1:0]            source_height_reg;
    logic [isc_pkg::SCALE_W-1:0] inverse_scale_reg;
    logic                        interp_mode_reg;

    logic           fq_valid;
    logic           fq_ready;
    isc_pkg::work_t fq_entry;
    logic           qb_valid;
    logic           qb_ready;
    isc_pkg::work_t qb_entry;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            source_width_reg  <= 10'd512;
            source_height_reg <= 10'd512;
            inverse_scale_reg <= isc_pkg::SCALE_ONE;
            interp_mode_reg   <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_WIDTH:  source_width_reg  <= cfg_data[DIM_W-1:0];
                REG_HEIGHT: source_height_reg <= cfg_data[DIM_W-1:0];
                REG_SCALE:  inverse_scale_reg <= cfg_data;
                REG_MODE:   interp_mode_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    isc_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mode       (s_mode),
        .s_coord_x    (s_coord_x),
        .s_coord_y    (s_coord_y),
        .s_pixel_in   (s_pixel_in),
        .source_width (source_width_reg),
        .source_height(source_height_reg),
        .inverse_scale(inverse_scale_reg),
        .interp_mode  (interp_mode_reg),
        .q_valid      (fq_valid),
        .q_ready      (fq_ready),
        .q_entry      (fq_entry)
    );

    isc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_valid(fq_valid),
        .push_ready(fq_ready),
        .push_data (fq_entry),
        .pop_valid (qb_valid),
        .pop_ready (qb_ready),
        .pop_data  (qb_entry)
    );

    isc_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (qb_valid),
        .q_ready    (qb_ready),
        .q_entry    (qb_entry),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_x    (m_out_x),
        .m_out_y    (m_out_y),
        .m_pixel_out(m_pixel_out),
        .m_outside  (m_outside)
    );

endmodule

// ===== rtl/core/isc_checker.sv =====
// Port-level checks for the image scaler top level, and the bind that attaches them.
// Depends on isc_pkg and image_scaler_nearest_bilinear.
module isc_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [isc_pkg::COORD_W-1:0]   m_out_x,
    input logic [isc_pkg::COORD_W-1:0]   m_out_y,
    input logic [isc_pkg::PIX_W-1:0]     m_pixel_out,
    input logic                          m_outside
);

    // stalled result holds
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_x) && $stable(m_out_y)
            && $stable(m_pixel_out) && $stable(m_outside))
        else $error("result changed while stalled");

    // a point outside the source is always white
    a_outside_white: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_outside |-> m_pixel_out == isc_pkg::WHITE_PIXEL)
        else $error("outside result not white");

    // reset drops any pending result and opens the input
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("state not cleared by reset");

    // a result cannot appear right after reset without an input transfer
    a_no_early_result: assert property (@(posedge aclk)
        !aresetn ##1 aresetn |=> !m_valid)
        else $error("result without input after reset");

endmodule

bind image_scaler_nearest_bilinear isc_checker u_isc_checker (.*);
